// ===== rtl/protobuf_wire_field_scanner_assert.svh =====
// Assertion macros for the scanner back end.
// Every macro samples on i_clk and is silent while i_rst_n is low.
`ifndef PROTOBUF_WIRE_FIELD_SCANNER_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_SCANNER_ASSERT_SVH

// Check a condition at every clock edge.
`define PWFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define PWFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pwfs_pkg.sv =====
`default_nettype none

package pwfs_pkg;

    // Field widths of the stream payloads
    localparam int DATA_W       = 8;
    localparam int FN_W         = 61;
    localparam int WT_W         = 3;
    localparam int VAL_W        = 64;
    localparam int OFF_W        = 32;
    localparam int ST_W         = 3;
    localparam int MASK_W       = 32;
    localparam int OUT_TDATA_W  = FN_W + WT_W + VAL_W + OFF_W;

    // Configuration and sizing defaults
    localparam int                POS_BITS_DEF = 32;
    localparam logic [MASK_W-1:0] MASK_RESET   = 32'd30;
    localparam int                QDEPTH       = 4;

    // Varint layout
    localparam int         VARINT_GROUP    = 7;
    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

    // Wire types
    localparam logic [WT_W-1:0] WT_VARINT  = 3'd0;
    localparam logic [WT_W-1:0] WT_FIXED64 = 3'd1;
    localparam logic [WT_W-1:0] WT_LEN     = 3'd2;
    localparam logic [WT_W-1:0] WT_FIXED32 = 3'd5;

    // Payload sizes of the fixed wire types
    localparam logic [VAL_W-1:0] FIXED64_LEN = 64'd8;
    localparam logic [VAL_W-1:0] FIXED32_LEN = 64'd4;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_VALUE,
        PH_LENGTH,
        PH_SKIP
    } t_phase;

    typedef enum logic [ST_W-1:0] {
        ST_OK,
        ST_TOO_LONG,
        ST_BAD_WIRE,
        ST_WRONG_TYPE,
        ST_TRUNC
    } t_status;

    // One classified byte in the queue between front and back
    typedef struct packed {
        logic       last;
        logic       cont;
        logic [6:0] low7;
    } t_qitem;

    // One result item
    typedef struct packed {
        logic [FN_W-1:0]  field_number;
        logic [WT_W-1:0]  wire_kind;
        logic [VAL_W-1:0] value;
        logic [OFF_W-1:0] payload_offset;
        t_status          status;
        logic             eom;
    } t_result;

    // Bit offset of varint group cnt
    function automatic logic [5:0] varint_shift(input logic [3:0] cnt);
        return 6'(VARINT_GROUP * int'(cnt));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pwfs_front.sv =====
`default_nettype none

module pwfs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [pwfs_pkg::DATA_W-1:0]   i_in_data,
    input  wire logic                          i_in_last,
    output logic                               o_q_valid,
    output pwfs_pkg::t_qitem                   o_q_item,
    input  wire logic                          i_q_pop
);
    import pwfs_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_qitem             r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    t_qitem             cls_item;

    // Classify the byte: continuation bit and seven payload bits
    always_comb begin
        cls_item.last = i_in_last;
        cls_item.cont = i_in_data[DATA_W-1];
        cls_item.low7 = i_in_data[DATA_W-2:0];
    end

    assign o_in_ready = (r_count != CNT_W'(QDEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    // Store the item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!push && i_q_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pwfs_back.sv =====
`default_nettype none

module pwfs_back #(
    parameter int POSITION_BITS = pwfs_pkg::POS_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [pwfs_pkg::MASK_W-1:0]   i_mask,
    input  wire logic                          i_q_valid,
    input  wire pwfs_pkg::t_qitem              i_q_item,
    output logic                               o_q_pop,
    output logic                               o_res_valid,
    output pwfs_pkg::t_result                  o_res,
    input  wire logic                          i_res_ready
);
    import pwfs_pkg::*;

    // Message state
    t_phase                   r_phase,  n_phase;
    logic [3:0]               r_cnt,    n_cnt;
    logic [VAL_W-1:0]         r_acc,    n_acc;
    logic [FN_W-1:0]          r_fn,     n_fn;
    logic [WT_W-1:0]          r_wt,     n_wt;
    logic [VAL_W-1:0]         r_rem,    n_rem;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [POSITION_BITS-1:0] r_start,  n_start;
    logic                     r_drop,   n_drop;

    // Output register
    logic                     r_ov;
    t_result                  r_out;

    // Decode of the current byte
    logic [VAL_W-1:0]         acc_or;
    logic [FN_W-1:0]          tag_fn;
    logic [WT_W-1:0]          tag_wt;
    logic                     tag_wrong;
    logic                     tag_badwt;
    logic                     cnt_at_max;
    logic                     is_err;
    logic [VAL_W-1:0]         rem_dec;
    logic [POSITION_BITS-1:0] pos_inc;
    logic                     pop;

    // Result of the current byte
    logic                     res_valid;
    logic [FN_W-1:0]          res_fn;
    logic [WT_W-1:0]          res_wt;
    logic [VAL_W-1:0]         res_val;
    logic [POSITION_BITS-1:0] res_off_pos;
    logic [OFF_W-1:0]         res_off;
    t_status                  res_st;

    // Take a byte when the output register is free or being drained
    assign pop     = i_q_valid && (!r_ov || i_res_ready);
    assign o_q_pop = pop;

    // Decode the byte against the running state
    assign acc_or     = r_acc | (VAL_W'(i_q_item.low7) << varint_shift(r_cnt));
    assign tag_fn     = acc_or[VAL_W-1:WT_W];
    assign tag_wt     = acc_or[WT_W-1:0];
    assign tag_wrong  = (tag_fn[FN_W-1:5] == '0) && i_mask[tag_fn[4:0]] && (tag_wt != WT_LEN);
    assign tag_badwt  = !((tag_wt == WT_VARINT) || (tag_wt == WT_FIXED64) ||
                          (tag_wt == WT_LEN) || (tag_wt == WT_FIXED32));
    assign cnt_at_max = (r_cnt >= VARINT_LAST_IDX);
    assign is_err     = (r_phase != PH_SKIP) &&
                        ((i_q_item.cont && cnt_at_max) ||
                         (!i_q_item.cont && (r_phase == PH_TAG) && (tag_wrong || tag_badwt)));
    assign rem_dec    = (r_rem != '0) ? (r_rem - VAL_W'(1)) : '0;
    assign pos_inc    = (r_pos == '1) ? r_pos : (r_pos + POSITION_BITS'(1));

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_fn    = r_fn;
        n_wt    = r_wt;
        n_rem   = r_rem;
        n_pos   = r_pos;
        n_start = r_start;
        n_drop  = r_drop;
        if (pop) begin
            if (!r_drop) begin
                case (r_phase)
                    PH_SKIP: begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = PH_TAG;
                            n_acc   = '0;
                        end
                    end
                    default: begin
                        if (i_q_item.cont) begin
                            n_acc = acc_or;
                            if (!cnt_at_max) begin
                                n_cnt = r_cnt + 4'd1;
                            end
                        end else begin
                            n_acc = '0;
                            n_cnt = '0;
                            case (r_phase)
                                PH_TAG: begin
                                    n_fn = tag_fn;
                                    n_wt = tag_wt;
                                    if (!tag_wrong && !tag_badwt && !i_q_item.last) begin
                                        n_start = pos_inc;
                                        case (tag_wt)
                                            WT_VARINT: n_phase = PH_VALUE;
                                            WT_LEN:    n_phase = PH_LENGTH;
                                            default: begin
                                                n_phase = PH_SKIP;
                                                n_rem   = (tag_wt == WT_FIXED64) ?
                                                          FIXED64_LEN : FIXED32_LEN;
                                                n_acc   = n_rem;
                                            end
                                        endcase
                                    end
                                end
                                PH_VALUE: begin
                                    n_phase = PH_TAG;
                                end
                                default: begin
                                    n_start = pos_inc;
                                    if (acc_or == '0) begin
                                        n_phase = PH_TAG;
                                    end else if (!i_q_item.last) begin
                                        n_phase = PH_SKIP;
                                        n_rem   = acc_or;
                                        n_acc   = acc_or;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
            // Clear the message on its last byte, else step the position and start dropping on an error
            if (i_q_item.last) begin
                n_phase = PH_TAG;
                n_cnt   = '0;
                n_acc   = '0;
                n_fn    = '0;
                n_wt    = '0;
                n_rem   = '0;
                n_pos   = '0;
                n_start = '0;
                n_drop  = 1'b0;
            end else begin
                n_pos = pos_inc;
                if (!r_drop && is_err) begin
                    n_drop = 1'b1;
                end
            end
        end
    end

    // Result of the current byte
    always_comb begin
        res_valid   = 1'b0;
        res_fn      = '0;
        res_wt      = '0;
        res_val     = '0;
        res_off_pos = '0;
        res_st      = ST_OK;
        if (!r_drop) begin
            case (r_phase)
                PH_SKIP: begin
                    if (rem_dec == '0) begin
                        res_valid   = 1'b1;
                        res_fn      = r_fn;
                        res_wt      = r_wt;
                        res_val     = r_acc;
                        res_off_pos = r_start;
                    end else if (i_q_item.last) begin
                        res_valid = 1'b1;
                        res_fn    = r_fn;
                        res_wt    = r_wt;
                        res_st    = ST_TRUNC;
                    end
                end
                default: begin
                    if (i_q_item.cont) begin
                        if (r_phase != PH_TAG) begin
                            res_fn = r_fn;
                            res_wt = r_wt;
                        end
                        if (cnt_at_max) begin
                            res_valid = 1'b1;
                            res_st    = ST_TOO_LONG;
                        end else if (i_q_item.last) begin
                            res_valid = 1'b1;
                            res_st    = ST_TRUNC;
                        end
                    end else begin
                        case (r_phase)
                            PH_TAG: begin
                                res_fn = tag_fn;
                                res_wt = tag_wt;
                                if (tag_wrong) begin
                                    res_valid = 1'b1;
                                    res_st    = ST_WRONG_TYPE;
                                end else if (tag_badwt) begin
                                    res_valid = 1'b1;
                                    res_st    = ST_BAD_WIRE;
                                end else if (i_q_item.last) begin
                                    res_valid = 1'b1;
                                    res_st    = ST_TRUNC;
                                end
                            end
                            PH_VALUE: begin
                                res_valid   = 1'b1;
                                res_fn      = r_fn;
                                res_wt      = r_wt;
                                res_val     = acc_or;
                                res_off_pos = r_start;
                            end
                            default: begin
                                res_fn = r_fn;
                                res_wt = r_wt;
                                if (acc_or == '0) begin
                                    res_valid   = 1'b1;
                                    res_off_pos = pos_inc;
                                end else if (i_q_item.last) begin
                                    res_valid = 1'b1;
                                    res_st    = ST_TRUNC;
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Saturate the payload offset to the output width, or zero-extend it when it fits
    generate
        if (POSITION_BITS > OFF_W) begin : g_off_sat
            assign res_off = (|res_off_pos[POSITION_BITS-1:OFF_W]) ?
                             '1 : res_off_pos[OFF_W-1:0];
        end else begin : g_off_ext
            assign res_off = OFF_W'(res_off_pos);
        end
    endgenerate

    // Hold message state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_fn    <= '0;
            r_wt    <= '0;
            r_rem   <= '0;
            r_pos   <= '0;
            r_start <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_fn    <= n_fn;
            r_wt    <= n_wt;
            r_rem   <= n_rem;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_drop  <= n_drop;
        end
    end

    // Load or drain the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (pop) begin
            r_ov <= res_valid;
        end else if (i_res_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && res_valid) begin
            r_out.field_number   <= res_fn;
            r_out.wire_kind      <= res_wt;
            r_out.value          <= res_val;
            r_out.payload_offset <= res_off;
            r_out.status         <= res_st;
            r_out.eom            <= i_q_item.last;
        end
    end

    assign o_res_valid = r_ov;
    assign o_res       = r_out;

`include "protobuf_wire_field_scanner_assert.svh"

    `PWFS_ASSERT(a_cnt_range, r_cnt <= VARINT_LAST_IDX, "varint byte count out of range")
    `PWFS_ASSERT(a_skip_rem, (r_phase != PH_SKIP) || (r_rem != '0), "skip with nothing left")
    `PWFS_ASSERT(a_no_pop_stall, !(r_ov && !i_res_ready && pop), "byte taken over held result")
    `PWFS_ASSERT(a_drop_quiet, !(r_drop && res_valid), "result while dropping")
    `PWFS_ASSERT_NEXT(a_last_clears, pop && i_q_item.last, !r_drop && (r_pos == '0), "no clear")

endmodule

`default_nettype wire

// ===== rtl/protobuf_wire_field_scanner.sv =====
// Protobuf wire-format field scanner.
// Input stream: one message byte per item in s_axis_tdata, s_axis_tlast on
// the final byte of each message. Output stream: one item per completed
// field or per error, with the field number, wire type, value or payload
// length and payload offset in m_axis_tdata, the status in m_axis_tuser and
// m_axis_tlast set when the item came from the last byte of the message.
// Config: i_cfg_we writes i_cfg_wdata to the bytes-only field mask.
// Throughput: one byte per cycle while no result is held; each byte makes one pass
// through the parser state machine in the back end.
// Output timing: a result is valid on m_axis in the cycle after its byte leaves
// the four-entry byte queue; a byte taken into an empty queue passes the queue
// memory and then the output register.
// Reset: the queue empties, the parser returns to expecting a tag at byte
// position zero and the mask returns to its default (fields 1 to 4).
// Stall: a held result blocks the back end; the queue keeps taking bytes
// until it is full, then s_axis_tready drops.
`default_nettype none

module protobuf_wire_field_scanner #(
    parameter int POSITION_BITS = pwfs_pkg::POS_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pwfs_pkg::MASK_W-1:0]        i_cfg_wdata,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] data_byte
    input  wire logic [pwfs_pkg::DATA_W-1:0]        s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [60:0] field_number, [63:61] wire_kind, [127:64] value,
    // [159:128] payload_offset
    output logic [pwfs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // [2:0] status
    output logic [pwfs_pkg::ST_W-1:0]               m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import pwfs_pkg::*;

    logic [MASK_W-1:0] r_mask;
    logic              q_valid;
    t_qitem            q_item;
    logic              q_pop;
    t_result           res;

    // Hold the bytes-only field mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    pwfs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_data  (s_axis_tdata),
        .i_in_last  (s_axis_tlast),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    pwfs_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask      (r_mask),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    // Pack the result item
    assign m_axis_tdata = {res.payload_offset, res.value, res.wire_kind, res.field_number};
    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.eom;

endmodule

`default_nettype wire
